@@ rtl/core/sha256_digest_engine_assert.svh @@
// Assertion macros for the SHA-256 digest engine.
`ifndef SHA256_DIGEST_ENGINE_ASSERT_SVH
`define SHA256_DIGEST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(label, clk, rst_n, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define SHA_ASSERT(label, clk, rst_n, prop, msg)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/sha_pkg.sv @@
// Shared types, constants and functions of the SHA-256 digest engine.
package sha_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} sha_out_t;

	// one request from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} sha_cmd_t;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	localparam logic [255:0] InitHash = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [7:0] PadByte = 8'h80;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
			endcase
			return k;
		end
	endfunction
endpackage

@@ rtl/core/sha_front.sv @@
// Input stage and request queue: drops empty items, buffers the rest.
module sha_front import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  sha_in_t  in_item,
	output logic     cmd_valid,
	input  logic     cmd_take,
	output sha_cmd_t cmd
);
	sha_cmd_t         mem_q [QDepth];
	logic [QAw-1:0]   wr_q, rd_q;
	logic [QAw:0]     cnt_q;
	logic             acc, keep;

	assign full      = (cnt_q == (QAw+1)'(QDepth));
	assign acc       = push && !full;
	// items with neither flag change nothing
	assign keep      = acc && (in_item.byte_valid || in_item.end_of_message);
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			mem_q[wr_q] <= '{in_item.data_byte, in_item.byte_valid, in_item.end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (keep) wr_q <= wr_q + 1'b1;
			if (cmd_take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAw+1)'(keep) - (QAw+1)'(cmd_take);
		end
	end
endmodule

@@ rtl/core/sha_core.sv @@
// Block assembly, padding, 64-round compression and digest output.
module sha_core import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_take,
	input  sha_cmd_t cmd,
	output logic     empty,
	input  logic     pop,
	output sha_out_t result
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StPad  = 3'd1;
	localparam logic [2:0] StRnd  = 3'd2;
	localparam logic [2:0] StAdd  = 3'd3;
	localparam logic [2:0] StOut  = 3'd4;

	logic [2:0]   st_q;
	logic [31:0]  w_q [16];
	logic [255:0] h_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]   pos_q, rnd_q;
	logic [63:0]  len_q;
	logic         fin_q;   // message end pending: pad then emit
	logic         lenin_q; // length field already written
	logic [2:0]   oidx_q;

	logic [31:0] wm2, wm15, s0, s1, wnew, wcur, e1, ch, e0, mj, t1, t2;
	logic [7:0]  pbyte;
	logic [7:0]  in_byte;
	logic        do_byte;
	logic        padfirst_q, padfirst;

	always_comb begin
		wm2  = w_q[14];
		wm15 = w_q[1];
		s1   = {wm2[16:0], wm2[31:17]} ^ {wm2[18:0], wm2[31:19]} ^ (wm2 >> 10);
		s0   = {wm15[6:0], wm15[31:7]} ^ {wm15[17:0], wm15[31:18]} ^ (wm15 >> 3);
		wnew = s1 + w_q[9] + s0 + w_q[0];
		wcur = w_q[0];
		e1   = {e_q[5:0], e_q[31:6]} ^ {e_q[10:0], e_q[31:11]} ^ {e_q[24:0], e_q[31:25]};
		ch   = (e_q & f_q) ^ (~e_q & g_q);
		t1   = hh_q + e1 + ch + round_k(rnd_q) + wcur;
		e0   = {a_q[1:0], a_q[31:2]} ^ {a_q[12:0], a_q[31:13]} ^ {a_q[21:0], a_q[31:22]};
		mj   = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t2   = e0 + mj;
	end

	// length bytes, big-endian, in positions 56..63
	always_comb begin
		pbyte = 8'h00;
		if (pos_q >= 6'd56 && lenin_q) pbyte = len_q[{3'd7 - pos_q[2:0], 3'b000} +: 8];
	end

	assign cmd_take = (st_q == StIdle) && cmd_valid;
	assign empty    = (st_q != StOut);
	assign result   = '{h_q[255 - 32*oidx_q -: 32], oidx_q == 3'd7};

	assign padfirst = padfirst_q;

	// schedule window shifts as a byte lane: 16 words, byte enters at the low end
	always_comb begin
		do_byte = 1'b0;
		in_byte = pbyte;
		if (st_q == StIdle && cmd_valid && cmd.byte_valid) begin
			do_byte = 1'b1;
			in_byte = cmd.data_byte;
		end else if (st_q == StPad) begin
			do_byte = 1'b1;
			in_byte = (pos_q >= 6'd56 && lenin_q) ? pbyte : (padfirst ? PadByte : 8'h00);
		end
	end

	always_ff @(posedge clk) begin
		if (do_byte) begin
			for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			w_q[15] <= {w_q[15][23:0], in_byte};
		end else if (st_q == StRnd) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle; h_q <= InitHash; pos_q <= '0; len_q <= '0; rnd_q <= '0;
			fin_q <= 1'b0; lenin_q <= 1'b0; oidx_q <= '0; padfirst_q <= 1'b0;
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q} <= '0;
		end else begin
			case (st_q)
			StIdle: if (cmd_valid) begin
				fin_q <= cmd.end_of_message;
				padfirst_q <= 1'b1;
				lenin_q <= 1'b0;
				if (cmd.byte_valid) begin
					len_q <= len_q + 64'd8;
					pos_q <= pos_q + 1'b1;
					if (pos_q == 6'd63) begin
						st_q <= StRnd; rnd_q <= '0;
						{a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q} <= h_q;
					end else if (cmd.end_of_message) st_q <= StPad;
				end else if (cmd.end_of_message) st_q <= StPad;
			end
			StPad: begin
				padfirst_q <= 1'b0;
				pos_q <= pos_q + 1'b1;
				// length goes in only if room remained after the 0x80 byte
				if (pos_q == 6'd55) lenin_q <= 1'b1;
				if (pos_q == 6'd63) begin
					st_q <= StRnd; rnd_q <= '0;
					{a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q} <= h_q;
				end
			end
			StRnd: begin
				{a_q, b_q, c_q, d_q} <= {t1 + t2, a_q, b_q, c_q};
				{e_q, f_q, g_q, hh_q} <= {d_q + t1, e_q, f_q, g_q};
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == 6'd63) st_q <= StAdd;
			end
			StAdd: begin
				h_q <= {h_q[255:224] + a_q, h_q[223:192] + b_q, h_q[191:160] + c_q,
					h_q[159:128] + d_q, h_q[127:96] + e_q, h_q[95:64] + f_q,
					h_q[63:32] + g_q, h_q[31:0] + hh_q};
				if (!fin_q) st_q <= StIdle;
				else if (lenin_q) begin st_q <= StOut; oidx_q <= '0; end
				else st_q <= StPad;
			end
			StOut: if (pop) begin
				oidx_q <= oidx_q + 1'b1;
				if (oidx_q == 3'd7) begin
					st_q <= StIdle; h_q <= InitHash; len_q <= '0; pos_q <= '0;
					fin_q <= 1'b0; lenin_q <= 1'b0;
				end
			end
			default: st_q <= StIdle;
			endcase
		end
	end
endmodule

@@ rtl/core/sha256_digest_engine.sv @@
// Top level of the SHA-256 digest engine.
// SHA-256 over a byte stream. Bytes enter a four-entry request queue and are
// absorbed one per cycle while the core is idle; each full 64-byte block then
// goes through the 64 rounds and the chaining add, during which no bytes are
// taken, the queue fills and full rises. On an end item the engine pads (one
// or two pad blocks), compresses, and offers eight digest words h0 first, one
// per pop. The sustained rate is set by the single round unit: no byte of the
// next block is taken while a block of 64 bytes is compressed.
module sha256_digest_engine import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  sha_in_t  in_item,
	output logic     empty,
	input  logic     pop,
	output sha_out_t result
);
`include "sha256_digest_engine_assert.svh"
	logic     cmd_valid, cmd_take;
	sha_cmd_t cmd;

	sha_front u_front (.clk, .arst_n, .push, .full, .in_item, .cmd_valid, .cmd_take, .cmd);
	sha_core  u_core (.clk, .arst_n, .cmd_valid, .cmd_take, .cmd, .empty, .pop, .result);

	`SHA_ASSERT(a_take_valid, clk, arst_n, cmd_take |-> cmd_valid, "take from empty queue")
	`SHA_ASSERT_NEXT(a_pop_hold, clk, arst_n, (!empty && !pop), !empty, "result dropped")
endmodule
